// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared cell type, function codes, character codes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // One screen cell: attribute byte over character byte.
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  // Function codes of an input transaction.
  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_CLEAR = 3'd1;
  localparam logic [2:0] FN_GET   = 3'd2;
  localparam logic [2:0] FN_SET   = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;

  // Character and attribute constants.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

endpackage

// ===== rtl/tcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  char_code;
  logic [6:0]  new_column;
  logic [4:0]  new_row;
  logic [10:0] cell_index;

  modport source (output valid, func, char_code, new_column, new_row, cell_index,
                  input ready);
  modport sink   (input valid, func, char_code, new_column, new_row, cell_index,
                  output ready);
endinterface

interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_column;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;

  modport source (output valid, cursor_column, cursor_row, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_row, cell_char, cell_attr,
                  output ready);
endinterface

// ===== rtl/tcw_cell_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell memory
// Single write port and single registered read port over the screen cells.
// ----------------------------------------------------------------------------
module tcw_cell_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  // Write when enabled and registered read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcw_addr_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console address unit
// Shared row-times-width plus offset calculator for cell reads and character writes.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
  parameter int WIDTH = 80,
  parameter int RW    = 5,
  parameter int AW    = 11
) (
  input  logic [RW-1:0] row,
  input  logic [AW-1:0] offset,
  output logic [AW-1:0] addr
);

  logic [AW:0] prod;
  logic [AW:0] sum;

  // Constant multiply by the row length, then add the column or offset.
  assign prod = (AW+1)'(row) * (AW+1)'(WIDTH);
  assign sum  = prod + (AW+1)'(offset);
  assign addr = sum[AW-1:0];

endmodule

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Teletype console over a WIDTH by HEIGHT screen of attribute/character cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_ch (write char, clear, get cursor, set cursor, read
//   cell); every request yields exactly one result on out_ch with the cursor
//   after the request and, for read cell, the cell's bytes. cfg_we/cfg_wdata
//   load the text attribute used for written and blanked cells.
// Sequencing:
//   Write char (without a scroll), get and set cursor produce their result
//   in the cycle after the transaction; read cell first passes through the
//   registered memory read and ST_READ. A line feed or wrap on the bottom row
//   scrolls; clear blanks every cell. Both are paced by the single memory
//   write port moving one cell per cycle. in_ch is not ready meanwhile.
// Reset:
//   After rst_n the block runs a clearing pass that blanks every cell with
//   attribute 0x0F; in_ch stays not ready during it.
// Stall:
//   The result sits in an output register; a new request is taken when that
//   register is empty or its result is being taken, otherwise the block waits.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_ch,
  tcw_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int CELLS = WIDTH * HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(WIDTH);
  localparam int RW    = $clog2(HEIGHT);
  localparam logic [AW-1:0] SCROLL_LIM = AW'(CELLS - WIDTH);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(HEIGHT - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          quiet_r, quiet_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic [7:0]    out_attr_r, out_attr_nxt;

  logic          accept;
  logic          load;
  logic [7:0]    rsp_char;
  logic [7:0]    rsp_attr;
  logic          adv;
  logic [15:0]   col_ext;
  logic [15:0]   row_ext;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;
  logic [RW-1:0] ua_row;
  logic [AW-1:0] ua_off;
  logic [AW-1:0] ua_addr;

  // Shared address calculator.
  tcw_addr_unit #(
    .WIDTH (WIDTH),
    .RW    (RW),
    .AW    (AW)
  ) u_addr (
    .row    (ua_row),
    .offset (ua_off),
    .addr   (ua_addr)
  );

  // Screen cell store.
  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ua_addr),
    .rdata (mem_rdata)
  );

  // Handshakes.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.cell_char     = out_char_r;
  assign out_ch.cell_attr     = out_attr_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    attr_nxt   = cfg_we ? cfg_wdata : attr_r;
    idx_nxt    = idx_r;
    wr_idx_nxt = wr_idx_r;
    pend_nxt   = pend_r;
    quiet_nxt  = quiet_r;
    load       = 1'b0;
    rsp_char   = 8'd0;
    rsp_attr   = 8'd0;
    adv        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = '{attr: (quiet_r ? RESET_ATTR : attr_r), ch: BLANK_CHAR};
    ua_row     = row_r;
    ua_off     = AW'(col_r);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.func == FN_READ) begin
          ua_row = '0;
          ua_off = AW'(in_ch.cell_index);
        end
        if (accept) begin
          case (in_ch.func)
            FN_WRITE: begin
              if (in_ch.char_code == CH_NEWLINE) begin
                col_nxt = '0;
                adv     = 1'b1;
              end else if (in_ch.char_code == CH_RETURN) begin
                col_nxt = '0;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ua_addr;
                mem_wdata = '{attr: attr_r, ch: in_ch.char_code};
                if (col_r == LAST_COL) begin
                  col_nxt = '0;
                  adv     = 1'b1;
                end else begin
                  col_nxt = col_r + CW'(1);
                end
              end
              // Advance to the next row, scrolling from the bottom row.
              if (adv && (row_r == LAST_ROW)) begin
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_SCROLL;
              end else begin
                if (adv) begin
                  row_nxt = row_r + RW'(1);
                end
                load = 1'b1;
              end
            end
            FN_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = ST_FILL;
            end
            FN_SET: begin
              col_nxt = (32'(in_ch.new_column) < WIDTH) ? CW'(in_ch.new_column) : LAST_COL;
              row_nxt = (32'(in_ch.new_row) < HEIGHT) ? RW'(in_ch.new_row) : LAST_ROW;
              load    = 1'b1;
            end
            FN_READ: begin
              if (32'(in_ch.cell_index) < CELLS) begin
                state_nxt = ST_READ;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      // Registered read data is back.
      ST_READ: begin
        load      = 1'b1;
        rsp_char  = mem_rdata.ch;
        rsp_attr  = mem_rdata.attr;
        state_nxt = ST_IDLE;
      end

      // Move each row up one: read the cell one row below, write it in the next cycle.
      ST_SCROLL: begin
        ua_row = RW'(1);
        ua_off = idx_r;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = mem_rdata;
        end
        if (idx_r != SCROLL_LIM) begin
          wr_idx_nxt = idx_r;
          idx_nxt    = idx_r + AW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end
      end

      // Blank cells from the current index through the last one.
      ST_FILL: begin
        mem_we = 1'b1;
        if (idx_r == LAST_CELL) begin
          quiet_nxt = 1'b0;
          load      = !quiet_r;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register.
  assign col_ext = 16'(col_nxt);
  assign row_ext = 16'(row_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = col_ext[6:0];
      out_row_nxt   = row_ext[4:0];
      out_char_nxt  = rsp_char;
      out_attr_nxt  = rsp_attr;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      quiet_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      quiet_r     <= quiet_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wr_idx_r   <= wr_idx_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

endmodule
